### src/hwi_pkg.sv
// shared types and constants for the histogram window integral block
`timescale 1ns / 1ps
`default_nettype none
package hwi_pkg;

  // result width and the wide view used for saturation
  localparam int PROB_W = 64;
  localparam int WIDE_W = 128;

  // query sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDB0  = 7'b0000010,
    S_RDBN  = 7'b0000100,
    S_CHK   = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  // sequencer to walk datapath
  typedef struct packed {
    logic clear;
    logic issue;
  } walk_ctl_t;

  // walk datapath to sequencer
  typedef struct packed {
    logic busy;
  } walk_sts_t;

endpackage
`default_nettype wire

### src/hwi_req_if.sv
// request channel: table loads and window queries
`timescale 1ns / 1ps
`default_nettype none
interface hwi_req_if #(
  parameter int IW = 9,
  parameter int EW = 32,
  parameter int DW = 24
);
  logic          valid;
  logic          ready;
  logic          req_type;
  logic [IW-1:0] entry_index;
  logic [EW-1:0] entry_bound;
  logic [DW-1:0] entry_density;
  logic [EW-1:0] centre_value;
  logic [EW-1:0] lower_width;
  logic [EW-1:0] upper_width;

  modport source (
    output valid, req_type, entry_index, entry_bound, entry_density,
           centre_value, lower_width, upper_width,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_bound, entry_density,
           centre_value, lower_width, upper_width,
    output ready
  );
endinterface
`default_nettype wire

### src/hwi_res_if.sv
// result channel: window integral
`timescale 1ns / 1ps
`default_nettype none
interface hwi_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] probability;
  logic        window_outside;

  modport source (output valid, probability, window_outside, input ready);
  modport sink (input valid, probability, window_outside, output ready);
endinterface
`default_nettype wire

### src/hwi_ram.sv
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module hwi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/hwi_walk.sv
// group walk datapath: overlap, product and saturating sum
`timescale 1ns / 1ps
`default_nettype none
module hwi_walk #(
  parameter int EW = 32,
  parameter int DW = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire hwi_pkg::walk_ctl_t       ctl,
  input  wire logic [EW-1:0]            b0,
  input  wire logic [EW-1:0]            lo,
  input  wire logic [EW-1:0]            hi,
  input  wire logic [EW-1:0]            bound_rd,
  input  wire logic [DW-1:0]            dens_rd,
  output logic [hwi_pkg::PROB_W-1:0]    sum,
  output hwi_pkg::walk_sts_t            sts
);
  import hwi_pkg::*;

  localparam int PW = EW + DW;

  logic          iss_v;
  logic          va;
  logic          vb;
  logic [EW-1:0] prev;
  logic [EW-1:0] diff;
  logic [DW-1:0] dens_q;
  logic [PW-1:0] prod;

  logic [EW-1:0]     a_clip;
  logic [EW-1:0]     b_clip;
  logic [WIDE_W-1:0] prod_wide;
  logic [PROB_W-1:0] prod_sat;
  logic [PROB_W:0]   sum_wide;

  // stage valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_v <= 1'b0;
      va    <= 1'b0;
      vb    <= 1'b0;
    end else begin
      iss_v <= ctl.issue;
      va    <= iss_v;
      vb    <= va;
    end
  end

  // clip the group to the window
  always_comb begin
    a_clip = (prev > lo) ? prev : lo;
    b_clip = (bound_rd < hi) ? bound_rd : hi;
  end

  // overlap width, previous bound tracks the lower edge of the next group
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      prev <= b0;
    end else if (iss_v) begin
      prev   <= bound_rd;
      diff   <= (b_clip > a_clip) ? (b_clip - a_clip) : '0;
      dens_q <= dens_rd;
    end
  end

  // width times density
  always_ff @(posedge clk) begin
    if (va) begin
      prod <= PW'(diff) * PW'(dens_q);
    end
  end

  // saturate the product, then add with saturation
  always_comb begin
    prod_wide = WIDE_W'(prod);
    prod_sat  = (|prod_wide[WIDE_W-1:PROB_W]) ? '1 : prod_wide[PROB_W-1:0];
    sum_wide  = {1'b0, sum} + {1'b0, prod_sat};
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum <= '0;
    end else if (vb) begin
      sum <= sum_wide[PROB_W] ? '1 : sum_wide[PROB_W-1:0];
    end
  end

  assign sts.busy = iss_v | va | vb;

endmodule
`default_nettype wire

### src/histogram_window_integral.sv
// top level: histogram density store and window integral sequencer
// a load request writes the tables as it is accepted; the block stays ready
// a query reads the first and last boundary, checks the window, walks the n groups
// in use, one read of both memories per group; an empty or outside window skips it
// the output register lets the next request in while a result waits
// synchronous active-high reset clears control state; the memories are not cleared
`timescale 1ns / 1ps
`default_nettype none
module histogram_window_integral #(
  parameter int MAX_GROUPS   = 256,
  parameter int ENERGY_BITS  = 32,
  parameter int DENSITY_BITS = 24,
  parameter int IW           = $clog2(MAX_GROUPS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [IW-1:0] cfg_wdata,
  hwi_req_if.sink            req,
  hwi_res_if.source          res
);
  import hwi_pkg::*;

  localparam int EW   = ENERGY_BITS;
  localparam int DW   = DENSITY_BITS;
  localparam int DA_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  state_t state;
  state_t state_next;

  logic [IW-1:0]     group_count;
  logic [IW-1:0]     n_clip;
  logic [IW-1:0]     n_q;
  logic [IW-1:0]     gi;
  logic [EW-1:0]     lo_raw;
  logic [EW:0]       hi_raw;
  logic              empty_q;
  logic [EW-1:0]     b0;
  logic [EW-1:0]     lo;
  logic [EW-1:0]     hi;
  logic              outside_q;
  logic              outside_now;
  logic              out_v;
  logic [PROB_W-1:0] out_prob;
  logic              out_outside;

  logic              acc;
  logic              load_acc;
  logic              query_acc;
  logic              bwe;
  logic              dwe;
  logic [IW-1:0]     b_raddr;
  logic [DA_W-1:0]   d_raddr;
  logic [EW-1:0]     bound_rd;
  logic [DW-1:0]     dens_rd;
  logic [PROB_W-1:0] sum;
  walk_ctl_t         wctl;
  walk_sts_t         wsts;

  // request handshake
  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid & req.ready;
  assign load_acc  = acc & ~req.req_type;
  assign query_acc = acc & req.req_type;

  // group count register
  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= IW'(1);
    end else if (cfg_we) begin
      group_count <= cfg_wdata;
    end
  end

  // groups in use
  always_comb begin
    if (group_count == '0) begin
      n_clip = IW'(1);
    end else if (group_count > IW'(MAX_GROUPS)) begin
      n_clip = IW'(MAX_GROUPS);
    end else begin
      n_clip = group_count;
    end
  end

  // table writes straight from the load request
  assign bwe = load_acc & (req.entry_index <= IW'(MAX_GROUPS));
  assign dwe = load_acc & (req.entry_index < IW'(MAX_GROUPS));

  // read addresses by phase
  always_comb begin
    b_raddr = '0;
    if (state == S_RDBN) begin
      b_raddr = n_q;
    end else if (state == S_WALK) begin
      b_raddr = gi + IW'(1);
    end
    d_raddr = gi[DA_W-1:0];
  end

  hwi_ram #(.WIDTH(EW), .DEPTH(MAX_GROUPS + 1), .AW(IW)) u_bound_ram (
    .clk   (clk),
    .we    (bwe),
    .waddr (req.entry_index),
    .wdata (req.entry_bound),
    .raddr (b_raddr),
    .rdata (bound_rd)
  );

  hwi_ram #(.WIDTH(DW), .DEPTH(MAX_GROUPS), .AW(DA_W)) u_dens_ram (
    .clk   (clk),
    .we    (dwe),
    .waddr (req.entry_index[DA_W-1:0]),
    .wdata (req.entry_density),
    .raddr (d_raddr),
    .rdata (dens_rd)
  );

  // window ends before clipping, captured at the query request
  always_ff @(posedge clk) begin
    if (query_acc) begin
      n_q     <= n_clip;
      lo_raw  <= (req.centre_value >= req.lower_width) ?
                 (req.centre_value - req.lower_width) : '0;
      hi_raw  <= {1'b0, req.centre_value} + {1'b0, req.upper_width};
      empty_q <= (req.lower_width == '0) && (req.upper_width == '0);
    end
  end

  // domain test against the first and last boundary in use
  assign outside_now = empty_q || (lo_raw > bound_rd) || (hi_raw < {1'b0, b0});

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (query_acc) state_next = S_RDB0;
      S_RDB0:  state_next = S_RDBN;
      S_RDBN:  state_next = S_CHK;
      S_CHK:   state_next = outside_now ? S_DONE : S_WALK;
      S_WALK:  if (gi == n_q - IW'(1)) state_next = S_DRAIN;
      S_DRAIN: if (!wsts.busy) state_next = S_DONE;
      S_DONE:  if (!out_v || res.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // boundary capture, clipping and group counter
  always_ff @(posedge clk) begin
    if (state == S_RDBN) begin
      b0 <= bound_rd;
    end
    if (state == S_CHK) begin
      outside_q <= outside_now;
      lo        <= (lo_raw > b0) ? lo_raw : b0;
      hi        <= (hi_raw > {1'b0, bound_rd}) ? bound_rd : hi_raw[EW-1:0];
      gi        <= '0;
    end else if (state == S_WALK) begin
      gi <= gi + IW'(1);
    end
  end

  assign wctl.clear = (state == S_CHK);
  assign wctl.issue = (state == S_WALK);

  hwi_walk #(.EW(EW), .DW(DW)) u_walk (
    .clk      (clk),
    .rst      (rst),
    .ctl      (wctl),
    .b0       (b0),
    .lo       (lo),
    .hi       (hi),
    .bound_rd (bound_rd),
    .dens_rd  (dens_rd),
    .sum      (sum),
    .sts      (wsts)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (state == S_DONE && (!out_v || res.ready)) begin
      out_v <= 1'b1;
    end else if (res.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_v || res.ready)) begin
      out_prob    <= outside_q ? '0 : sum;
      out_outside <= outside_q;
    end
  end

  assign res.valid          = out_v;
  assign res.probability    = out_prob;
  assign res.window_outside = out_outside;

endmodule
`default_nettype wire

### src/hwi_checker.sv
// port-level checks for the histogram window integral block and its bind
`timescale 1ns / 1ps
`default_nettype none
module hwi_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_type,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] probability,
  input wire logic        window_outside
);

  // an outside window always reports zero
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_outside |-> probability == 64'd0)
    else $error("outside window with nonzero probability");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(probability)
                                && $stable(window_outside))
    else $error("stalled result changed");

  // a load never makes a result appear
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_type && !out_valid |=> !out_valid)
    else $error("result after a load request");

  // a query keeps the block busy on the following cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_type |=> !in_ready)
    else $error("ready right after a query request");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind histogram_window_integral hwi_checker u_hwi_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (req.valid),
  .in_ready       (req.ready),
  .in_type        (req.req_type),
  .out_valid      (res.valid),
  .out_ready      (res.ready),
  .probability    (res.probability),
  .window_outside (res.window_outside)
);
`default_nettype wire
